// ----- rtl/rss_pkg.sv -----
// ---------------------------------------------------------------------------
// rss_pkg
// Types, byte codes and helpers shared by the reply stream scanner modules.
// ---------------------------------------------------------------------------
package rss_pkg;

  localparam logic [7:0] LF_BYTE    = 8'h0A;
  localparam logic [7:0] D_BYTE     = 8'h64;
  localparam logic [7:0] NUL_BYTE   = 8'h00;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7E;

  localparam logic [3:0] MIN_LEN_RESET = 4'd4;
  localparam logic [3:0] RUN_MAX       = 4'hF;

  localparam logic [1:0] KIND_HOST = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] reply_kind;
    logic       host_normal;
    logic [7:0] text_char;
    logic       text_valid;
    logic       last_of_run;
  } out_item_t;

  // Results of one input item: one or two slots.
  typedef struct packed {
    logic      dual;
    out_item_t slot1;
    out_item_t slot0;
  } res_bundle_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LF   = 4'b0010,
    PH_LF_D = 4'b0100,
    PH_TEXT = 4'b1000
  } phase_t;

  function automatic logic is_printable(input logic [7:0] b);
    return (b >= PRINT_LO) && (b <= PRINT_HI);
  endfunction

  function automatic out_item_t mk_item(input logic [1:0] kind, input logic normal,
                                        input logic [7:0] ch, input logic valid);
    out_item_t r;
    r.reply_kind  = kind;
    r.host_normal = normal;
    r.text_char   = ch;
    r.text_valid  = valid;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

// ----- rtl/rss_front.sv -----
// ---------------------------------------------------------------------------
// rss_front
// Byte classifier: tracks the prefix and text run state, builds the result
// bundle of each accepted item and holds the minimum length register.
// ---------------------------------------------------------------------------
module rss_front import rss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  in_item_t    item,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  output logic        push,
  output res_bundle_t bundle
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] run_r, run_nxt;
  logic [3:0] min_r;
  logic [1:0] n;
  out_item_t  s0, s1;
  logic [7:0] b;
  logic       pr;

  assign b  = item.rx_byte;
  assign pr = is_printable(b);

  always_comb begin
    phase_nxt = phase_r;
    run_nxt   = run_r;
    n         = 2'd0;
    s0        = mk_item(KIND_HOST, 1'b0, 8'h00, 1'b0);
    s1        = mk_item(KIND_HOST, 1'b0, 8'h00, 1'b0);
    if (accept) begin
      if (item.opcode == OP_FLUSH) begin
        if (phase_r == PH_TEXT) begin
          n  = 2'd1;
          s0 = mk_item(KIND_END, 1'b0, 8'h00, run_r >= min_r);
        end
        phase_nxt = PH_IDLE;
        run_nxt   = 4'd0;
      end else begin
        unique case (phase_r)
          PH_IDLE, PH_LF: begin
            if (phase_r == PH_LF && b == D_BYTE) begin
              phase_nxt = PH_LF_D;
            end else if (b == LF_BYTE) begin
              phase_nxt = PH_LF;
            end else if (pr) begin
              n         = 2'd1;
              s0        = mk_item(KIND_CHAR, 1'b0, b, 1'b0);
              run_nxt   = 4'd1;
              phase_nxt = PH_TEXT;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_LF_D: begin
            if (b == LF_BYTE || b == NUL_BYTE) begin
              n         = 2'd1;
              s0        = mk_item(KIND_HOST, b == LF_BYTE, 8'h00, 1'b0);
              phase_nxt = PH_IDLE;
            end else begin
              // drop the leading LF; the 0x64 opens a run, then rescan b
              n  = 2'd2;
              s0 = mk_item(KIND_CHAR, 1'b0, D_BYTE, 1'b0);
              if (pr) begin
                s1        = mk_item(KIND_CHAR, 1'b0, b, 1'b0);
                run_nxt   = 4'd2;
                phase_nxt = PH_TEXT;
              end else begin
                s1        = mk_item(KIND_END, 1'b0, 8'h00, 4'd1 >= min_r);
                run_nxt   = 4'd0;
                phase_nxt = PH_IDLE;
              end
            end
          end
          PH_TEXT: begin
            n = 2'd1;
            if (pr) begin
              s0      = mk_item(KIND_CHAR, 1'b0, b, 1'b0);
              run_nxt = (run_r == RUN_MAX) ? run_r : run_r + 4'd1;
            end else begin
              s0        = mk_item(KIND_END, 1'b0, 8'h00, run_r >= min_r);
              run_nxt   = 4'd0;
              phase_nxt = (b == LF_BYTE) ? PH_LF : PH_IDLE;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            run_nxt   = 4'd0;
          end
        endcase
      end
    end
    if (n == 2'd1) s0.last_of_run = 1'b1;
    if (n == 2'd2) s1.last_of_run = 1'b1;
  end

  assign push         = accept && (n != 2'd0);
  assign bundle.dual  = (n == 2'd2);
  assign bundle.slot0 = s0;
  assign bundle.slot1 = s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      run_r   <= 4'd0;
      min_r   <= MIN_LEN_RESET;
    end else begin
      phase_r <= phase_nxt;
      run_r   <= run_nxt;
      if (cfg_wr_en) min_r <= cfg_wr_data;
    end
  end

  a_run_zero_outside_text: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_TEXT) |-> (run_r == 4'd0))
    else $error("run length nonzero outside a text run");

  a_text_has_run: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TEXT) |-> (run_r != 4'd0))
    else $error("text run with zero length");

endmodule

// ----- rtl/rss_queue.sv -----
// ---------------------------------------------------------------------------
// rss_queue
// Short bundle queue between the classifier and the result serializer.
// ---------------------------------------------------------------------------
module rss_queue import rss_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  res_bundle_t wr_data,
  output logic        full,
  input  logic        pop,
  output logic        empty,
  output res_bundle_t head
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);

  res_bundle_t   mem [Depth];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(Depth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + AW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + AW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + CW'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CW'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(Depth))
    else $error("queue count beyond depth");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("bundle pushed into a full queue");

endmodule

// ----- rtl/rss_back.sv -----
// ---------------------------------------------------------------------------
// rss_back
// Result serializer: hands out the one or two results of the head bundle.
// ---------------------------------------------------------------------------
module rss_back import rss_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  res_bundle_t q_head,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output out_item_t   out_item
);

  logic idx_r;
  logic take;

  assign out_empty = q_empty;
  assign out_item  = idx_r ? q_head.slot1 : q_head.slot0;
  assign take      = out_pop && !q_empty;
  // advance to the next bundle after its last result
  assign q_pop     = take && (idx_r || !q_head.dual);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 1'b0;
    end else if (take) begin
      idx_r <= !q_pop;
    end
  end

  a_idx_on_dual: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r |-> (!q_empty && q_head.dual))
    else $error("second slot selected without a two-result bundle");

  a_last_ends_bundle: assert property (@(posedge clk) disable iff (!rst_n)
    (take && out_item.last_of_run) |-> q_pop)
    else $error("last result did not release its bundle");

endmodule

// ----- rtl/reply_stream_scanner_core.sv -----
// ---------------------------------------------------------------------------
// reply_stream_scanner_core
// Byte stream scanner for host query replies and printable text runs.
// ---------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_push / in_full    in_item  (opcode, rx_byte)
//  out      output     out_pop / out_empty  out_item (kind, flags, char, last)
//  cfg      input      cfg_wr_en            cfg_wr_data (min_text_length)
//
// One item is accepted per cycle while the bundle queue has room; its results
// are registered in the bundle queue before they appear on the out ports.
// An item gives zero, one or two results; the serializer hands out one result
// per cycle while out_pop is high, so input stalls only when the QueueDepth
// bundle queue fills. Synchronous active-low reset clears the scan state,
// queue and serializer and loads min_text_length with 4.
// ---------------------------------------------------------------------------
module reply_stream_scanner_core import rss_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  in_item_t   in_item,
  output logic       out_empty,
  input  logic       out_pop,
  output out_item_t  out_item,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data
);

  logic        accept;
  logic        f_push;
  res_bundle_t f_bundle;
  logic        q_pop, q_empty;
  res_bundle_t q_head;

  assign accept = in_push && !in_full;

  rss_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .item        (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (f_push),
    .bundle      (f_bundle)
  );

  rss_queue #(.Depth(QueueDepth)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .wr_data (f_bundle),
    .full    (in_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .head    (q_head)
  );

  rss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ----- tb/rss_reply_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rss_reply_checker
// Watches the in, out and cfg channels of the reply stream scanner, predicts
// the replies of every accepted item and compares each popped reply with the
// oldest prediction. Reports the failure count and the predictions waiting.
// ---------------------------------------------------------------------------
module rss_reply_checker import rss_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic       in_full,
  input  in_item_t   in_item,
  input  logic       out_empty,
  input  logic       out_pop,
  input  out_item_t  out_item,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  output int         fail_count,
  output int         pending
);

  localparam int MAX_REPLIES = 3;
  localparam int SHOWN_ERRORS = 10;

  phase_t     scan_ph = PH_IDLE;
  logic [3:0] run_len = '0;
  logic [3:0] min_len = MIN_LEN_RESET;

  out_item_t  step_replies [MAX_REPLIES];
  int         step_cnt;
  out_item_t  reply_q [$];
  int         errors = 0;

  function automatic logic is_text_byte(input logic [7:0] b);
    return (b >= PRINT_LO) && (b <= PRINT_HI);
  endfunction

  function void add_reply(input logic [1:0] kind, input logic normal,
                          input logic [7:0] ch, input logic valid);
    out_item_t r;
    r.reply_kind  = kind;
    r.host_normal = normal;
    r.text_char   = ch;
    r.text_valid  = valid;
    r.last_of_run = 1'b0;
    if (step_cnt < MAX_REPLIES) begin
      step_replies[step_cnt] = r;
      step_cnt++;
    end
  endfunction

  function void close_run();
    add_reply(KIND_END, 1'b0, 8'h00, run_len >= min_len);
    run_len = '0;
    scan_ph = PH_IDLE;
  endfunction

  function void scan_from_idle(input logic [7:0] b);
    if (b == LF_BYTE) begin
      scan_ph = PH_LF;
    end else if (is_text_byte(b)) begin
      add_reply(KIND_CHAR, 1'b0, b, 1'b0);
      run_len = 4'd1;
      scan_ph = PH_TEXT;
    end
  endfunction

  // Every phase but the one after 0x0A 0x64.
  function void scan_simple(input logic [7:0] b);
    case (scan_ph)
      PH_TEXT: begin
        if (is_text_byte(b)) begin
          add_reply(KIND_CHAR, 1'b0, b, 1'b0);
          if (run_len != RUN_MAX) run_len = run_len + 4'd1;
        end else begin
          close_run();
          scan_from_idle(b);
        end
      end
      PH_LF: begin
        if (b == D_BYTE) begin
          scan_ph = PH_LF_D;
        end else begin
          scan_ph = PH_IDLE;
          scan_from_idle(b);
        end
      end
      default: begin
        scan_ph = PH_IDLE;
        scan_from_idle(b);
      end
    endcase
  endfunction

  function void scan_item(input in_item_t it);
    step_cnt = 0;
    if (it.opcode == OP_FLUSH) begin
      if (scan_ph == PH_TEXT) close_run();
      scan_ph = PH_IDLE;
      run_len = '0;
    end else if (scan_ph == PH_LF_D) begin
      if (it.rx_byte == LF_BYTE || it.rx_byte == NUL_BYTE) begin
        add_reply(KIND_HOST, it.rx_byte == LF_BYTE, 8'h00, 1'b0);
        scan_ph = PH_IDLE;
      end else begin
        // Drop the 0x0A, rescan 0x64 and then the third byte.
        scan_ph = PH_IDLE;
        scan_from_idle(D_BYTE);
        scan_simple(it.rx_byte);
      end
    end else begin
      scan_simple(it.rx_byte);
    end
    if (step_cnt > 0) step_replies[step_cnt - 1].last_of_run = 1'b1;
    for (int i = 0; i < step_cnt; i++) reply_q.push_back(step_replies[i]);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      scan_ph = PH_IDLE;
      run_len = '0;
      min_len = MIN_LEN_RESET;
      reply_q.delete();
    end else begin
      if (out_pop && !out_empty) begin
        if (reply_q.size() == 0) begin
          if (errors < SHOWN_ERRORS)
            $display("%0t: unexpected reply kind %0d normal %0b char %02h valid %0b last %0b",
                     $time, out_item.reply_kind, out_item.host_normal, out_item.text_char,
                     out_item.text_valid, out_item.last_of_run);
          errors++;
        end else begin
          want = reply_q.pop_front();
          if (out_item.reply_kind !== want.reply_kind ||
              out_item.host_normal !== want.host_normal ||
              out_item.text_char !== want.text_char ||
              out_item.text_valid !== want.text_valid ||
              out_item.last_of_run !== want.last_of_run) begin
            if (errors < SHOWN_ERRORS) begin
              $write("%0t: reply mismatch (expected/actual) kind %0d/%0d normal %0b/%0b",
                     $time, want.reply_kind, out_item.reply_kind,
                     want.host_normal, out_item.host_normal);
              $display(" char %02h/%02h valid %0b/%0b last %0b/%0b",
                       want.text_char, out_item.text_char,
                       want.text_valid, out_item.text_valid,
                       want.last_of_run, out_item.last_of_run);
            end
            errors++;
          end
        end
      end
      // The user must write the register only while the block is idle; the block itself does not enforce it.
      if (cfg_wr_en) min_len = cfg_wr_data;
      if (in_push && !in_full) scan_item(in_item);
    end
    pending <= reply_q.size();
    fail_count <= errors;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the reply stream scanner: directed host queries, broken and
// short prefixes, text runs and flushes, then random well-formed sequences
// mixed with noise under several minimum lengths, with random stalls on both
// channels. The checker beside the block judges every reply.
// ---------------------------------------------------------------------------
module tb_top import rss_pkg::*; ();

  localparam int HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES = QUEUE_DEPTH + 6;
  localparam int PHASE_ITEMS = 62;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  in_item_t   in_item = '0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  out_item_t  out_item;
  logic       cfg_wr_en = 1'b0;
  logic [3:0] cfg_wr_data = '0;
  int         fail_count;
  int         pending;

  bit calm = 1'b0;
  bit hold_req = 1'b0;

  reply_stream_scanner_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_item     (in_item),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  rss_reply_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_item     (in_item),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #200_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: random pops, a long hold-off on request, no stalls while calm.
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_pop <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  task automatic offer(input in_item_t it);
    in_item <= it;
    in_push <= 1'b1;
    do @(posedge clk); while (in_full);
    if (!calm && $urandom_range(99) < 20) begin
      in_push <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic send_rx(input logic [7:0] b);
    in_item_t it;
    it.opcode = OP_BYTE;
    it.rx_byte = b;
    offer(it);
  endtask

  task automatic send_flush();
    in_item_t it;
    it.opcode = OP_FLUSH;
    it.rx_byte = 8'($urandom_range(255));
    offer(it);
  endtask

  function automatic logic [7:0] text_byte();
    return 8'($urandom_range(PRINT_HI, PRINT_LO));
  endfunction

  // Hold the input until every predicted reply has been popped.
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_min_length(input logic [3:0] v);
    drain();
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(input int n_items);
    int sent;
    int pick;
    int len;
    int r;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_rx(LF_BYTE);
        send_rx(D_BYTE);
        send_rx($urandom_range(1) ? LF_BYTE : NUL_BYTE);
        sent += 3;
      end else if (pick < 65) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 12) : $urandom_range(8, 1);
        for (int i = 0; i < len; i++) send_rx(text_byte());
        sent += len + 1;
        case ($urandom_range(3))
          0: begin
            // End the run on a byte outside the printable range.
            r = $urandom_range(32 + 128, 0);
            send_rx((r < 32) ? 8'(r) : 8'(r - 32 + 8'h7F));
          end
          1: send_flush();
          2: send_rx(LF_BYTE);
          default: sent -= 1;
        endcase
      end else if (pick < 80) begin
        send_rx(LF_BYTE);
        if ($urandom_range(1)) begin
          send_rx(D_BYTE);
          sent += 1;
        end
        send_rx(8'($urandom_range(255)));
        sent += 2;
      end else if (pick < 90) begin
        send_flush();
        sent += 1;
      end else begin
        send_rx(8'($urandom_range(255)));
        sent += 1;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Minimum length stays at its reset value here.
    send_rx(LF_BYTE);            // host reply with 0x00
    send_rx(D_BYTE);
    send_rx(NUL_BYTE);
    send_rx(LF_BYTE);            // broken after 0x0A, rescan 'A'
    send_rx(8'h41);
    send_rx(PRINT_LO);
    send_rx(PRINT_HI);
    send_rx(LF_BYTE);            // short run ended by 0x0A, then normal host reply
    send_rx(D_BYTE);
    send_rx(LF_BYTE);
    send_rx(LF_BYTE);            // broken third byte, printable
    send_rx(D_BYTE);
    send_rx(8'h5A);
    send_rx(PRINT_HI);
    send_rx(PRINT_LO);
    send_rx(8'h80);              // valid run ended by a byte
    send_rx(LF_BYTE);            // broken third byte, not printable
    send_rx(D_BYTE);
    send_rx(8'hFF);
    send_rx(LF_BYTE);            // flush with pending prefixes
    send_flush();
    send_rx(LF_BYTE);
    send_rx(D_BYTE);
    send_flush();
    send_flush();                // flush while idle
    send_rx(8'h71);              // flush during a run
    send_flush();

    set_min_length(4'd1);
    run_phase(PHASE_ITEMS);

    // Fill the block while the receiver holds off; the run also saturates.
    set_min_length(4'd15);
    hold_req = 1'b1;
    for (int i = 0; i < 20; i++) send_rx(text_byte());
    send_flush();
    run_phase(PHASE_ITEMS - 21);

    set_min_length(4'd0);
    calm = 1'b1;
    run_phase(PHASE_ITEMS);
    calm = 1'b0;

    set_min_length(4'($urandom_range(14, 2)));
    run_phase(PHASE_ITEMS);

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
